// ===== rtl/kplc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kplc_pkg;

	localparam int PASS_LEN = 4;
	localparam int CNT_W    = $clog2(PASS_LEN + 1);
	localparam int PW_W     = 4 * PASS_LEN;

	localparam logic [15:0] PASSWORD_RST  = 16'h1234;
	localparam logic [8:0]  THRESHOLD_RST = 9'd30;

	localparam logic [3:0] KEY_STAR = 4'd10;
	localparam logic [3:0] KEY_HASH = 4'd11;

	localparam logic [6:0] FAN_BIT = 7'b000_0001;

	// register byte addresses
	localparam logic [2:0] ADDR_PASSWORD  = 3'd0;
	localparam logic [2:0] ADDR_THRESHOLD = 3'd4;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_ENTRY  = 3'd1,
		MODE_MAIN   = 3'd2,
		MODE_LIGHTS = 3'd3,
		MODE_DEVICE = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		SCR_NONE    = 4'd0,
		SCR_PROMPT  = 4'd1,
		SCR_ECHO    = 4'd2,
		SCR_CORRECT = 4'd3,
		SCR_WRONG   = 4'd4,
		SCR_INVALID = 4'd5,
		SCR_BYE     = 4'd6,
		SCR_MAIN    = 4'd7,
		SCR_LIGHTS  = 4'd8,
		SCR_DEVICE  = 4'd9,
		SCR_CLEARED = 4'd10
	} screen_t;

	typedef struct packed {
		logic [6:0] port_bits;
		screen_t    screen;
		mode_t      mode_now;
	} result_t;

	function automatic logic [6:0] dev_mask(input logic [2:0] sel);
		logic [6:0] m;
		unique case (sel)
			3'd0:    m = 7'b000_0010;
			3'd1:    m = 7'b000_0100;
			3'd2:    m = 7'b000_1000;
			3'd3:    m = 7'b011_0000;
			3'd4:    m = 7'b100_0000;
			default: m = 7'b000_0000;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/keypad_password_lock_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake         payload
// in        sink       in_valid/stall    action, key_code, sample
// out       source     out_valid/stall   port_bits, screen, mode_now
// apb       slave      psel/penable      paddr, pwdata, prdata
//
// One item per cycle while in_stall is low: the mode logic updates the
// state at the input transfer and the result lands in the output register
// at that same edge, where out_valid shows it. A skid register catches one
// result while the output is stalled; in_stall rises only while it is full.
// Reset clears the mode, entry, selection and port bits and loads password
// 0x1234 and threshold 30.

module keypad_password_lock_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              action,
	input  wire logic [3:0]        key_code,
	input  wire logic [9:0]        sample,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [6:0]             port_bits,
	output logic [3:0]             screen,
	output logic [2:0]             mode_now,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import kplc_pkg::*;

	logic [15:0]            password_q;
	logic [8:0]             threshold_q;
	mode_t                  mode_q, mode_d;
	logic [2:0]             sel_q, sel_d;
	logic [3:0]             digit_q [PASS_LEN];
	logic [3:0]             digit_d [PASS_LEN];
	logic [CNT_W-1:0]       count_q, count_d;
	logic [6:0]             bits_q, bits_d;
	screen_t                scr_d;
	logic                   match;
	logic [PW_W-1:0]        pw_ext;
	logic                   in_xfer, out_take, cfg_wr;
	result_t                res, out_q, skid_q;
	logic                   out_valid_q, skid_valid_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == ADDR_THRESHOLD[2])
			prdata = {23'd0, threshold_q};
		else
			prdata = {16'd0, password_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			password_q  <= PASSWORD_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == ADDR_THRESHOLD[2])
				threshold_q <= pwdata[8:0];
			else
				password_q <= pwdata[15:0];
		end
	end

	// password compare
	assign pw_ext = PW_W'(password_q);

	always_comb begin
		match = (count_q == CNT_W'(PASS_LEN));
		for (int k = 0; k < PASS_LEN; k++) begin
			if (digit_q[k] != pw_ext[4*(PASS_LEN-1-k) +: 4])
				match = 1'b0;
		end
	end

	// mode logic
	always_comb begin
		mode_d  = mode_q;
		sel_d   = sel_q;
		digit_d = digit_q;
		count_d = count_q;
		bits_d  = bits_q;
		scr_d   = SCR_NONE;
		if (action) begin
			if (sample[9:1] > threshold_q)
				bits_d = bits_q | FAN_BIT;
			else
				bits_d = bits_q & ~FAN_BIT;
		end else if (key_code <= KEY_HASH) begin
			unique case (mode_q)
				MODE_ENTRY: begin
					if (key_code == KEY_HASH) begin
						if (match) begin
							mode_d = MODE_MAIN;
							scr_d  = SCR_CORRECT;
						end else begin
							scr_d = SCR_WRONG;
						end
					end else if (key_code == KEY_STAR) begin
						for (int k = 0; k < PASS_LEN; k++)
							digit_d[k] = '0;
						count_d = '0;
						scr_d   = SCR_CLEARED;
					end else begin
						// store only while the entry has room
						for (int k = 0; k < PASS_LEN; k++) begin
							if (count_q == CNT_W'(k))
								digit_d[k] = key_code;
						end
						if (count_q < CNT_W'(PASS_LEN))
							count_d = count_q + 1'b1;
						scr_d = SCR_ECHO;
					end
				end
				MODE_MAIN: begin
					priority case (key_code)
						4'd1: begin
							bits_d = bits_q & FAN_BIT;
							for (int k = 0; k < PASS_LEN; k++)
								digit_d[k] = '0;
							count_d = '0;
							mode_d  = MODE_IDLE;
							scr_d   = SCR_BYE;
						end
						4'd2: begin
							sel_d  = 3'd0;
							mode_d = MODE_DEVICE;
							scr_d  = SCR_DEVICE;
						end
						4'd4: begin
							sel_d  = 3'd4;
							mode_d = MODE_DEVICE;
							scr_d  = SCR_DEVICE;
						end
						4'd3: begin
							mode_d = MODE_LIGHTS;
							scr_d  = SCR_LIGHTS;
						end
						default: scr_d = SCR_INVALID;
					endcase
				end
				MODE_LIGHTS: begin
					if (key_code >= 4'd1 && key_code <= 4'd3) begin
						sel_d  = key_code[2:0];
						mode_d = MODE_DEVICE;
						scr_d  = SCR_DEVICE;
					end else if (key_code == 4'd4) begin
						mode_d = MODE_MAIN;
						scr_d  = SCR_MAIN;
					end else begin
						scr_d = SCR_INVALID;
					end
				end
				MODE_DEVICE: begin
					priority case (key_code)
						4'd1: bits_d = bits_q | dev_mask(sel_q);
						4'd2: bits_d = bits_q & ~dev_mask(sel_q);
						4'd3: begin
							if (sel_q >= 3'd1 && sel_q <= 3'd3) begin
								mode_d = MODE_LIGHTS;
								scr_d  = SCR_LIGHTS;
							end else begin
								mode_d = MODE_MAIN;
								scr_d  = SCR_MAIN;
							end
						end
						default: scr_d = SCR_INVALID;
					endcase
				end
				default: begin
					mode_d = MODE_IDLE;
					if (key_code == KEY_STAR) begin
						mode_d = MODE_ENTRY;
						scr_d  = SCR_PROMPT;
					end
				end
			endcase
		end
	end

	assign in_stall = skid_valid_q;
	assign in_xfer  = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			sel_q   <= '0;
			count_q <= '0;
			bits_q  <= '0;
			for (int k = 0; k < PASS_LEN; k++)
				digit_q[k] <= '0;
		end else if (in_xfer) begin
			mode_q  <= mode_d;
			sel_q   <= sel_d;
			count_q <= count_d;
			bits_q  <= bits_d;
			digit_q <= digit_d;
		end
	end

	assign res = '{port_bits: bits_d, screen: scr_d, mode_now: mode_d};

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take)
				skid_valid_q <= 1'b0;
		end else if (in_xfer) begin
			if (!out_valid_q || out_take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take)
				out_q <= skid_q;
		end else if (in_xfer) begin
			if (!out_valid_q || out_take)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign port_bits = out_q.port_bits;
	assign screen    = out_q.screen;
	assign mode_now  = out_q.mode_now;

endmodule

`default_nettype wire
